FILE: rtl/core/tsp_pkg.sv
// Shared types, widths and constants of the timestamp text parser.
// Used by timestamp_text_parser and its port checker; depends on nothing.
`default_nettype none

package tsp_pkg;

  // Fraction digits kept (10^-FRAC_DIGITS s units) and fraction digits consumed
  localparam int FRAC_DIGITS       = 9;
  localparam int MAX_FRAC_CONSUMED = 31;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int NS_W    = 30;
  localparam int ZONE_W  = 20;

  // Digit counter holds the year's 4 digits or the fraction's digit limit
  localparam int DCNT_W = (MAX_FRAC_CONSUMED >= 4) ? $clog2(MAX_FRAC_CONSUMED + 1) : 3;
  localparam int KEEP_W = $clog2(FRAC_DIGITS + 1);
  localparam int KIDX_W = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

  localparam int YEAR_MAX_DIGITS  = 4;
  localparam int FIELD_MAX_DIGITS = 2;

  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef enum logic [1:0] {
    ZS_NONE,
    ZS_PLUS,
    ZS_MINUS
  } zsign_t;

  // Parsed fields of one timestamp
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [NS_W-1:0]    ns;
    zsign_t             zsign;
    logic [FIELD_W-1:0] zone_hour;
    logic [FIELD_W-1:0] zone_minute;
  } stamp_t;

  // Weight of fraction digit k in output units, modulo 2^NS_W (constant args only)
  function automatic logic [NS_W-1:0] frac_weight(int k);
    logic [63:0] w;
    w = 64'd1;
    for (int i = 0; i < FRAC_DIGITS - 1 - k; i++) begin
      w = w * 64'd10;
    end
    return w[NS_W-1:0];
  endfunction

  // Append one decimal digit to a two-digit field
  function automatic logic [FIELD_W-1:0] mac10(logic [FIELD_W-1:0] a, logic [3:0] d);
    return FIELD_W'(a * FIELD_W'(10) + FIELD_W'(d));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/timestamp_text_parser.sv
// Timestamp text parser: one character per cycle in unless stalled, one field record per string out.
// Depends on tsp_pkg.
//
// Accepts 'YYYY-MM-DD HH:MM:SS[.fff][ ... +HH:MM]' one byte per clock and, on the
// byte flagged in_end_of_text, emits one record: the date and time fields as written,
// the fraction truncated to nanoseconds, and the zone offset in signed seconds.
// out_valid_res is 1 when the day field is nonzero. A byte is taken every cycle as
// long as results are taken; the last byte is folded into the accumulators as the
// record enters s1, and the zone offset is computed as it moves to the output register.
// The parser returns to its start state after each last byte, so strings may follow
// back to back. There are no configuration registers.
`default_nettype none

module timestamp_text_parser
  import tsp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [7:0]               in_char_byte,
  input  wire logic                     in_end_of_text,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_valid_res,
  output logic [YEAR_W-1:0]             out_year,
  output logic [FIELD_W-1:0]            out_month,
  output logic [FIELD_W-1:0]            out_day,
  output logic [FIELD_W-1:0]            out_hour,
  output logic [FIELD_W-1:0]            out_minute,
  output logic [FIELD_W-1:0]            out_second,
  output logic [NS_W-1:0]               out_nanoseconds,
  output logic signed [ZONE_W-1:0]      out_zone_offset_seconds
);

  typedef enum logic [3:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOND,
    PH_FRAC,
    PH_SEEK,
    PH_ZHOUR,
    PH_ZSEP,
    PH_ZMIN,
    PH_DONE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [KEEP_W-1:0]   kept_r, kept_nxt;
  stamp_t              acc_r, acc_nxt;

  stamp_t              s1_r;
  logic                s1_v_r;

  logic                in_fire, last_fire, out_free, s1_adv;
  logic                is_digit, do_seek;
  logic [3:0]          dig;
  logic [DCNT_W-1:0]   field_max;
  logic [7:0]          field_sep;
  phase_t              field_next;

  logic [NS_W-1:0]     frac_weight_c [FRAC_DIGITS];
  logic [ZONE_W-1:0]   off_mag;
  logic [ZONE_W-1:0]   off_val;

  // Constant weight of each kept fraction digit
  for (genvar g = 0; g < FRAC_DIGITS; g++) begin : g_weight
    assign frac_weight_c[g] = frac_weight(g);
  end

  // Handshake: a finished record waits in s1 or the output register
  assign out_free  = !out_valid || out_ready;
  assign s1_adv    = s1_v_r && out_free;
  assign in_ready  = !s1_v_r || out_free;
  assign in_fire   = in_valid && in_ready;
  assign last_fire = in_fire && in_end_of_text;

  // Separator and digit limit of the current date/time field
  always_comb begin
    field_max  = DCNT_W'(FIELD_MAX_DIGITS);
    field_sep  = CH_COLON;
    field_next = PH_SECOND;
    case (phase_r)
      PH_YEAR: begin
        field_max  = DCNT_W'(YEAR_MAX_DIGITS);
        field_sep  = CH_MINUS;
        field_next = PH_MONTH;
      end
      PH_MONTH: begin
        field_sep  = CH_MINUS;
        field_next = PH_DAY;
      end
      PH_DAY: begin
        field_sep  = CH_SPACE;
        field_next = PH_HOUR;
      end
      PH_HOUR: begin
        field_sep  = CH_COLON;
        field_next = PH_MINUTE;
      end
      default: begin
        field_sep  = CH_COLON;
        field_next = PH_SECOND;
      end
    endcase
  end

  // Fold one character into the parse state
  always_comb begin
    is_digit  = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);
    dig       = is_digit ? 4'(in_char_byte - CH_ZERO) : 4'd0;
    phase_nxt = phase_r;
    dcnt_nxt  = dcnt_r;
    kept_nxt  = kept_r;
    acc_nxt   = acc_r;
    do_seek   = 1'b0;

    case (phase_r)
      PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE: begin
        if (is_digit && (dcnt_r < field_max)) begin
          case (phase_r)
            PH_YEAR:  acc_nxt.year  = YEAR_W'(acc_r.year * YEAR_W'(10) + YEAR_W'(dig));
            PH_MONTH: acc_nxt.month = mac10(acc_r.month, dig);
            PH_DAY:   acc_nxt.day   = mac10(acc_r.day, dig);
            PH_HOUR:  acc_nxt.hour  = mac10(acc_r.hour, dig);
            default:  acc_nxt.minute = mac10(acc_r.minute, dig);
          endcase
          dcnt_nxt = DCNT_W'(dcnt_r + 1'b1);
        end else if ((dcnt_r != '0) && (in_char_byte == field_sep)) begin
          phase_nxt = field_next;
          dcnt_nxt  = '0;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_SECOND: begin
        if (is_digit && (dcnt_r < DCNT_W'(FIELD_MAX_DIGITS))) begin
          acc_nxt.second = mac10(acc_r.second, dig);
          dcnt_nxt       = DCNT_W'(dcnt_r + 1'b1);
        end else if (dcnt_r != '0) begin
          if (in_char_byte == CH_DOT) begin
            phase_nxt = PH_FRAC;
            dcnt_nxt  = '0;
          end else begin
            do_seek = 1'b1;
          end
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_digit && (dcnt_r < DCNT_W'(MAX_FRAC_CONSUMED))) begin
          dcnt_nxt = DCNT_W'(dcnt_r + 1'b1);
          // keep the leading digits, each already scaled to its final weight
          if (kept_r < KEEP_W'(FRAC_DIGITS)) begin
            acc_nxt.ns = NS_W'(acc_r.ns +
                               NS_W'(dig) * frac_weight_c[kept_r[KIDX_W-1:0]]);
            kept_nxt   = KEEP_W'(kept_r + 1'b1);
          end
        end else begin
          do_seek = 1'b1;
        end
      end
      PH_SEEK: begin
        do_seek = 1'b1;
      end
      PH_ZHOUR: begin
        if (is_digit) begin
          acc_nxt.zone_hour = mac10(acc_r.zone_hour, dig);
          dcnt_nxt          = DCNT_W'(dcnt_r + 1'b1);
          if (dcnt_r != '0) begin
            phase_nxt = PH_ZSEP;
          end
        end else if ((dcnt_r == '0) || (in_char_byte == CH_NUL)) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_ZSEP;
        end
      end
      PH_ZSEP: begin
        if (is_digit) begin
          acc_nxt.zone_minute = FIELD_W'(dig);
          phase_nxt           = PH_ZMIN;
        end else if (in_char_byte == CH_NUL) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_ZMIN: begin
        if (is_digit) begin
          acc_nxt.zone_minute = mac10(acc_r.zone_minute, dig);
        end
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // Search for the zone sign; a NUL ends parsing
    if (do_seek) begin
      phase_nxt = PH_SEEK;
      if (in_char_byte == CH_NUL) begin
        phase_nxt = PH_DONE;
      end else if ((in_char_byte == CH_PLUS) || (in_char_byte == CH_MINUS)) begin
        acc_nxt.zsign = (in_char_byte == CH_PLUS) ? ZS_PLUS : ZS_MINUS;
        phase_nxt     = PH_ZHOUR;
        dcnt_nxt      = '0;
      end
    end
  end

  // Zone offset of the finished record
  always_comb begin
    off_mag = ZONE_W'(ZONE_W'(s1_r.zone_hour) * ZONE_W'(SECS_PER_HOUR) +
                      ZONE_W'(s1_r.zone_minute) * ZONE_W'(SECS_PER_MIN));
    case (s1_r.zsign)
      ZS_PLUS:  off_val = off_mag;
      ZS_MINUS: off_val = ZONE_W'(-off_mag);
      default:  off_val = '0;
    endcase
  end

  // Parse state, finished-record stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_YEAR;
      dcnt_r    <= '0;
      kept_r    <= '0;
      acc_r     <= '0;
      s1_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // advance the parser; restart it after the last byte
      if (last_fire) begin
        phase_r <= PH_YEAR;
        dcnt_r  <= '0;
        kept_r  <= '0;
        acc_r   <= '0;
      end else if (in_fire) begin
        phase_r <= phase_nxt;
        dcnt_r  <= dcnt_nxt;
        kept_r  <= kept_nxt;
        acc_r   <= acc_nxt;
      end

      // hold the finished record until the output register is free
      if (last_fire) begin
        s1_r   <= acc_nxt;
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      // present the item
      if (s1_adv) begin
        out_valid               <= 1'b1;
        out_valid_res           <= (s1_r.day != '0);
        out_year                <= s1_r.year;
        out_month               <= s1_r.month;
        out_day                 <= s1_r.day;
        out_hour                <= s1_r.hour;
        out_minute              <= s1_r.minute;
        out_second              <= s1_r.second;
        out_nanoseconds         <= s1_r.ns;
        out_zone_offset_seconds <= off_val;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsp_checker.sv
// Port-level checks of timestamp_text_parser, bound to every instance of it.
// Depends on tsp_pkg.
`default_nettype none

module tsp_checker
  import tsp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [7:0]            in_char_byte,
  input wire logic                  in_end_of_text,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_valid_res,
  input wire logic [YEAR_W-1:0]     out_year,
  input wire logic [FIELD_W-1:0]    out_month,
  input wire logic [FIELD_W-1:0]    out_day,
  input wire logic [FIELD_W-1:0]    out_hour,
  input wire logic [FIELD_W-1:0]    out_minute,
  input wire logic [FIELD_W-1:0]    out_second,
  input wire logic [NS_W-1:0]       out_nanoseconds,
  input wire logic signed [ZONE_W-1:0] out_zone_offset_seconds
);

  // No item is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("item shown right after reset");

  // A waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_char_byte) && $stable(in_end_of_text))
    else $error("waiting input item changed");

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res) && $stable(out_year) &&
      $stable(out_month) && $stable(out_day) && $stable(out_hour) && $stable(out_minute) &&
      $stable(out_second) && $stable(out_nanoseconds) && $stable(out_zone_offset_seconds))
    else $error("stalled item changed");

  // An item into an empty output follows an accepted last byte through s1 and the output register
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_end_of_text, 2))
    else $error("item without a last byte");

  // The valid flag tracks the day field
  a_valid_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res == (out_day != '0)))
    else $error("valid flag disagrees with day");

endmodule

bind timestamp_text_parser tsp_checker u_tsp_checker (.*);

`default_nettype wire

FILE: tb/tb_timestamp_text_parser.sv
// Self-checking bench for timestamp_text_parser: directed and random timestamp strings,
// predicted per character and compared field by field under varied handshake pacing.
// Depends on tsp_pkg and timestamp_text_parser.
module tb_timestamp_text_parser;
  import tsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_CHARS = 280;
  localparam int MAX_PRINTS  = 50;

  // Parser position within the timestamp text
  typedef enum int {
    PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND,
    PH_FRAC, PH_SEEK, PH_ZHOUR, PH_ZSEP, PH_ZMIN, PH_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  typedef struct {
    logic                     valid_res;
    logic [YEAR_W-1:0]        year;
    logic [FIELD_W-1:0]       month;
    logic [FIELD_W-1:0]       day;
    logic [FIELD_W-1:0]       hour;
    logic [FIELD_W-1:0]       minute;
    logic [FIELD_W-1:0]       second;
    logic [NS_W-1:0]          ns;
    logic signed [ZONE_W-1:0] zone;
  } stamp_rec_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_char_byte = 8'h00;
  logic                     in_end_of_text = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_valid_res;
  logic [YEAR_W-1:0]        out_year;
  logic [FIELD_W-1:0]       out_month;
  logic [FIELD_W-1:0]       out_day;
  logic [FIELD_W-1:0]       out_hour;
  logic [FIELD_W-1:0]       out_minute;
  logic [FIELD_W-1:0]       out_second;
  logic [NS_W-1:0]          out_nanoseconds;
  logic signed [ZONE_W-1:0] out_zone_offset_seconds;

  timestamp_text_parser u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_char_byte            (in_char_byte),
    .in_end_of_text          (in_end_of_text),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_valid_res           (out_valid_res),
    .out_year                (out_year),
    .out_month               (out_month),
    .out_day                 (out_day),
    .out_hour                (out_hour),
    .out_minute              (out_minute),
    .out_second              (out_second),
    .out_nanoseconds         (out_nanoseconds),
    .out_zone_offset_seconds (out_zone_offset_seconds)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pending text, expected records and run statistics
  text_item_t  text_q[$];
  logic [7:0]  line_q[$];
  stamp_rec_t  expected_stamps_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          chars_queued = 0;
  int          chars_taken = 0;
  int          strings_queued = 0;
  int          stamps_checked = 0;
  int          mismatches = 0;
  int          cycles = 0;

  // Shadow copy of the parser state
  parse_phase_t ph;
  int unsigned  ndig, yr_acc, mo_acc, dy_acc, hr_acc, mi_acc, se_acc;
  int unsigned  frac_acc, frac_kept, zh_acc, zm_acc;
  zsign_t       zsign;

  task automatic report(string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic clear_parse();
    ph = PH_YEAR;
    ndig = 0;
    yr_acc = 0; mo_acc = 0; dy_acc = 0;
    hr_acc = 0; mi_acc = 0; se_acc = 0;
    frac_acc = 0; frac_kept = 0;
    zsign = ZS_NONE;
    zh_acc = 0; zm_acc = 0;
  endtask

  // Enter or continue the search for a zone sign
  task automatic seek_zone(logic [7:0] c);
    ph = PH_SEEK;
    if (c == CH_NUL) begin
      ph = PH_DONE;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      zsign = (c == CH_PLUS) ? ZS_PLUS : ZS_MINUS;
      ph = PH_ZHOUR;
      ndig = 0;
    end
  endtask

  // Fold one accepted character into the shadow state; queue a record on the last one
  task automatic parse_char(logic [7:0] c, logic last);
    logic        dig;
    int unsigned d, maxd;
    logic [7:0]  sep;
    longint unsigned ns;
    int          off;
    stamp_rec_t  rec;
    dig = (c >= CH_ZERO && c <= CH_NINE);
    d = dig ? int'(c - CH_ZERO) : 0;
    case (ph)
      PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE: begin
        maxd = (ph == PH_YEAR) ? YEAR_MAX_DIGITS : FIELD_MAX_DIGITS;
        sep = (ph == PH_DAY) ? CH_SPACE :
              (ph == PH_HOUR || ph == PH_MINUTE) ? CH_COLON : CH_MINUS;
        if (dig && ndig < maxd) begin
          case (ph)
            PH_YEAR:  yr_acc = yr_acc * 10 + d;
            PH_MONTH: mo_acc = mo_acc * 10 + d;
            PH_DAY:   dy_acc = dy_acc * 10 + d;
            PH_HOUR:  hr_acc = hr_acc * 10 + d;
            default:  mi_acc = mi_acc * 10 + d;
          endcase
          ndig++;
        end else if (ndig >= 1 && c == sep) begin
          ph = parse_phase_t'(ph + 1);
          ndig = 0;
        end else begin
          ph = PH_DONE;
        end
      end
      PH_SECOND: begin
        if (dig && ndig < FIELD_MAX_DIGITS) begin
          se_acc = se_acc * 10 + d;
          ndig++;
        end else if (ndig >= 1) begin
          if (c == CH_DOT) begin
            ph = PH_FRAC;
            ndig = 0;
          end else begin
            seek_zone(c);
          end
        end else begin
          ph = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (dig && ndig < MAX_FRAC_CONSUMED) begin
          ndig++;
          if (frac_kept < FRAC_DIGITS) begin
            frac_acc = frac_acc * 10 + d;
            frac_kept++;
          end
        end else begin
          seek_zone(c);
        end
      end
      PH_SEEK: seek_zone(c);
      PH_ZHOUR: begin
        if (dig) begin
          zh_acc = zh_acc * 10 + d;
          ndig++;
          if (ndig >= 2) ph = PH_ZSEP;
        end else if (ndig == 0 || c == CH_NUL) begin
          ph = PH_DONE;
        end else begin
          ph = PH_ZSEP;
        end
      end
      PH_ZSEP: begin
        if (dig) begin
          zm_acc = d;
          ph = PH_ZMIN;
        end else if (c == CH_NUL) begin
          ph = PH_DONE;
        end
      end
      PH_ZMIN: begin
        if (dig) zm_acc = zm_acc * 10 + d;
        ph = PH_DONE;
      end
      default: ph = PH_DONE;
    endcase

    if (last) begin
      // Scale the kept fraction digits up to nanoseconds
      ns = frac_acc;
      for (int k = frac_kept; k < FRAC_DIGITS; k++) ns = ns * 10;
      off = 0;
      if (zsign != ZS_NONE) begin
        off = zh_acc * SECS_PER_HOUR + zm_acc * SECS_PER_MIN;
        if (zsign == ZS_MINUS) off = -off;
      end
      rec.valid_res = (dy_acc != 0);
      rec.year      = YEAR_W'(yr_acc);
      rec.month     = FIELD_W'(mo_acc);
      rec.day       = FIELD_W'(dy_acc);
      rec.hour      = FIELD_W'(hr_acc);
      rec.minute    = FIELD_W'(mi_acc);
      rec.second    = FIELD_W'(se_acc);
      rec.ns        = NS_W'(ns);
      rec.zone      = ZONE_W'(off);
      expected_stamps_q.push_back(rec);
      clear_parse();
    end
  endtask

  // Compare one output record with the oldest expected one
  task automatic check_stamp();
    stamp_rec_t        want;
    logic signed [63:0] got_v[9];
    logic signed [63:0] want_v[9];
    string             names[9];
    if (expected_stamps_q.size() == 0) begin
      report($sformatf("record with no string pending (year %0d day %0d)", out_year, out_day));
    end else begin
      want = expected_stamps_q.pop_front();
      names = '{"valid_res", "year", "month", "day", "hour", "minute", "second",
                "nanoseconds", "zone_offset_seconds"};
      got_v[0] = out_valid_res;    want_v[0] = want.valid_res;
      got_v[1] = out_year;         want_v[1] = want.year;
      got_v[2] = out_month;        want_v[2] = want.month;
      got_v[3] = out_day;          want_v[3] = want.day;
      got_v[4] = out_hour;         want_v[4] = want.hour;
      got_v[5] = out_minute;       want_v[5] = want.minute;
      got_v[6] = out_second;       want_v[6] = want.second;
      got_v[7] = out_nanoseconds;  want_v[7] = want.ns;
      got_v[8] = out_zone_offset_seconds;
      want_v[8] = want.zone;
      for (int i = 0; i < 9; i++) begin
        if (got_v[i] !== want_v[i])
          report($sformatf("record %0d %s: got %0d, expected %0d",
                           stamps_checked, names[i], got_v[i], want_v[i]));
      end
      stamps_checked++;
    end
  endtask

  // Driver: predict on each accepted item, then load the next one or idle
  always @(posedge clk) begin : drive_text
    logic       load;
    text_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_char_byte, in_end_of_text);
        chars_taken++;
      end
      load = (!in_valid || in_ready) && text_q.size() > 0 &&
             ($urandom_range(0, 99) >= send_idle_pct);
      if (load) begin
        nxt = text_q.pop_front();
        in_valid       <= 1'b1;
        in_char_byte   <= nxt.ch;
        in_end_of_text <= nxt.last;
      end else if (!in_valid || in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check accepted records, stall the result side at random
  always @(posedge clk) begin : watch_records
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_stamp();
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // String building
  task automatic add_char(logic [7:0] c);
    line_q.push_back(c);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_digits(int n);
    repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Move the built string to the pending text, flagging its last character
  task automatic commit_line();
    if (line_q.size() == 0) line_q.push_back(8'($urandom_range(0, 255)));
    foreach (line_q[i]) text_q.push_back('{line_q[i], i == line_q.size() - 1});
    chars_queued += line_q.size();
    strings_queued++;
    line_q.delete();
  endtask

  function automatic logic [7:0] filler_char();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return "Z";
      2:       return "T";
      3:       return CH_COLON;
      4:       return "u";
      default: return ($urandom_range(0, 29) == 0) ? CH_NUL : "x";
    endcase
  endfunction

  // Mostly well-formed timestamp with random content and occasional breakage
  task automatic build_random_stamp();
    int         f, n;
    logic [7:0] sep;
    for (f = 0; f < 6; f++) begin
      n = (f == 0) ? $urandom_range(1, 4) : $urandom_range(1, 2);
      if ($urandom_range(0, 49) == 0) n = $urandom_range(0, 5);
      add_digits(n);
      if (f < 5) begin
        sep = (f == 2) ? CH_SPACE : (f < 2) ? CH_MINUS : CH_COLON;
        if ($urandom_range(0, 39) == 0) sep = 8'($urandom_range(0, 255));
        add_char(sep);
      end
    end
    // optional fraction, sometimes longer than the consumed limit
    if ($urandom_range(0, 1)) begin
      add_char(CH_DOT);
      if ($urandom_range(0, 4) == 0) add_digits($urandom_range(25, 36));
      else add_digits($urandom_range(0, 12));
    end
    repeat ($urandom_range(0, 3)) add_char(filler_char());
    // optional zone
    if ($urandom_range(0, 3) != 0) begin
      add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2;
      if ($urandom_range(0, 4) == 0) n = 1;
      add_digits(n);
      if (n < 2 || $urandom_range(0, 9) < 7)
        add_char($urandom_range(0, 3) == 0 ? filler_char() : CH_COLON);
      add_digits($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 2);
    end
    repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(0, 255)));
  endtask

  task automatic build_noise_string();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 1)) add_char(8'($urandom_range(0, 255)));
      else add_char($urandom_range(0, 1) ? filler_char() : CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Hold the sender until everything sent has come back
  task automatic drain();
    while (text_q.size() != 0 || in_valid || expected_stamps_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int send_pct[4];
    int recv_pct[4];
    int start;
    send_pct = '{0, 57, 0, 23};
    recv_pct = '{0, 0, 57, 23};
    clear_parse();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full stamp, extremes, zero day, long fraction, broken fields,
    // zone corner cases, NUL stop and bytes after the zone
    add_text("2024-01-31 23:59:59.123456789+05:30"); commit_line();
    add_text("9999-99-99 99:99:99.999999999999-99:99"); commit_line();
    add_text("0-0-0 0:0:0.5"); commit_line();
    add_text("1-2-3 4:5:6.1234567890123456789012345678901234-1:7"); commit_line();
    add_text("2024-01-02  03:04"); commit_line();
    add_text(" 2024-01-02"); commit_line();
    add_text("2024-+1-02"); commit_line();
    add_text("12345-01-02"); commit_line();
    add_text("2024-01-02 03:04:05 UTC"); commit_line();
    add_text("2024-01-02 03:04:05+"); commit_line();
    add_text("2024-01-02 03:04:05-Z"); commit_line();
    add_text("2024-01-02 03:04:05"); add_char(CH_NUL); add_text("+01:00"); commit_line();
    add_text("2024-01-02 03:04:05+1x2 tail"); commit_line();
    add_text("2024-01-02 03:04:055+0130"); commit_line();
    add_text("2024-01-02 03:04:05.+08"); commit_line();
    add_char("7"); commit_line();
    add_char(8'hff); commit_line();

    // Random strings under each pacing mode
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      start = chars_queued;
      while (chars_queued - start < PHASE_CHARS) begin
        if ($urandom_range(0, 4) != 0) build_random_stamp();
        else build_noise_string();
        commit_line();
      end
      drain();
    end

    // Let the block settle and catch stray records
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (expected_stamps_q.size() != 0)
      report($sformatf("%0d records never arrived", expected_stamps_q.size()));

    $display("Sent %0d strings (%0d characters) under four pacing modes, incl. corner cases",
             strings_queued, chars_taken);
    $display("Checked %0d records, %0d mismatches", stamps_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
